// File: rtl/core/pru_pkg.sv
// shared types and constants for the packed raw pixel unpacker
// no dependencies; imported by every module of the block
`default_nettype none

package pru_pkg;

  // frame size limits applied to the written geometry
  localparam int unsigned MAX_WIDTH  = 16384;
  localparam int unsigned MAX_HEIGHT = 16384;

  // field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RAW_W    = 12;
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned COORD_W  = 14;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned CMP_W    = 17;

  // pixels carried by one packed group
  localparam int unsigned GROUP_PIXELS = 9;
  localparam int unsigned IDX_W        = $clog2(GROUP_PIXELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_PIXELS - 1);

  // largest shift applied to a pixel
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd4;

  // depth of the group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_SHIFT  = 2'd2;

  // input transaction: one 16-byte group
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
  } pru_in_t;

  // output transaction: one pixel
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_in_group;
    logic               end_of_frame;
  } pru_out_t;

  // unpacked group held in the queue
  typedef logic [GROUP_PIXELS-1:0][RAW_W-1:0] pru_group_t;

  // geometry as the back end uses it: last column, last row, shift
  typedef struct packed {
    logic [DIM_W-1:0]   col_last;
    logic [DIM_W-1:0]   row_last;
    logic [SHIFT_W-1:0] shift;
  } pru_cfg_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } pru_qstat_t;

endpackage

`default_nettype wire

// File: rtl/core/pru_front.sv
// front end: configuration registers and group unpacking into the queue
// depends on pru_pkg
`default_nettype none

module pru_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  pru_pkg::pru_in_t            in_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pru_pkg::DIM_W-1:0]         cfg_data,
  input  wire  pru_pkg::pru_qstat_t         qstat,
  output logic                              push,
  output pru_pkg::pru_group_t               push_group,
  output pru_pkg::pru_cfg_t                 cfg
);
  import pru_pkg::*;

  logic [DIM_W-1:0]   col_last_r, col_last_nxt;
  logic [DIM_W-1:0]   row_last_r, row_last_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               cfg_wr;
  logic [CMP_W-1:0]   wr_ext;
  logic [DIM_W-1:0]   wr_m1;
  logic [WORD_W-1:0]  a0, a1, a2, a3;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign wr_ext    = CMP_W'(cfg_data);
  assign wr_m1     = cfg_data - DIM_W'(1);

  // clamp the written geometry and keep it as the last index
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    shift_nxt    = shift_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            col_last_nxt = '0;
          end else if (wr_ext > CMP_W'(MAX_WIDTH)) begin
            col_last_nxt = DIM_W'(MAX_WIDTH - 1);
          end else begin
            col_last_nxt = wr_m1;
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            row_last_nxt = '0;
          end else if (wr_ext > CMP_W'(MAX_HEIGHT)) begin
            row_last_nxt = DIM_W'(MAX_HEIGHT - 1);
          end else begin
            row_last_nxt = wr_m1;
          end
        end
        REG_VALUE_SHIFT: begin
          if (cfg_data[SHIFT_W-1:0] > MAX_SHIFT) begin
            shift_nxt = MAX_SHIFT;
          end else begin
            shift_nxt = cfg_data[SHIFT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // geometry registers, reset to a one by one frame and the largest shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= '0;
      row_last_r <= '0;
      shift_r    <= MAX_SHIFT;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      shift_r    <= shift_nxt;
    end
  end

  assign cfg = '{col_last: col_last_r, row_last: row_last_r, shift: shift_r};

  // accept a transaction whenever the queue has room
  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  // fixed bit layout of the nine 12-bit pixels
  assign a0 = in_data.word0;
  assign a1 = in_data.word1;
  assign a2 = in_data.word2;
  assign a3 = in_data.word3;

  always_comb begin
    push_group[0] = {a0[12:10], a0[8:0]};
    push_group[1] = {a0[25:20], a0[18:13]};
    push_group[2] = {a1[8:0],   a0[28:26]};
    push_group[3] = {a1[22:20], a1[18:10]};
    push_group[4] = {a2[5:0],   a1[28:23]};
    push_group[5] = {a2[18:10], a2[8:6]};
    push_group[6] = {a3[2:0],   a2[28:20]};
    push_group[7] = {a3[15:10], a3[8:3]};
    push_group[8] = {a3[28:20], a3[18:16]};
  end

endmodule

`default_nettype wire

// File: rtl/core/pru_queue.sv
// short queue of unpacked groups between front and back
// depends on pru_pkg
`default_nettype none

module pru_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire  pru_pkg::pru_group_t push_group,
  input  wire                       pop,
  output pru_pkg::pru_group_t       head_group,
  output pru_pkg::pru_qstat_t       qstat
);
  import pru_pkg::*;

  pru_group_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // group storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_group;
    end
  end

  assign head_group      = slot_r[rd_ptr_r];
  assign qstat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.not_empty = (count_r != '0);

endmodule

`default_nettype wire

// File: rtl/core/pru_back.sv
// back end: walks the head group pixel by pixel, tracks position, drives output
// depends on pru_pkg
`default_nettype none

module pru_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  pru_pkg::pru_cfg_t   cfg,
  input  wire  pru_pkg::pru_qstat_t qstat,
  input  wire  pru_pkg::pru_group_t head_group,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_ready,
  output pru_pkg::pru_out_t         out_data
);
  import pru_pkg::*;

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;
  pru_out_t           out_data_r, out_data_nxt;
  logic               slot_free;
  logic               emit;
  logic               row_end;
  logic               frame_end;
  logic               last_pix;
  logic [PIXEL_W-1:0] shifted;

  // output register frees when empty or being taken
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = slot_free && qstat.not_empty;

  // position compare against the current geometry
  assign row_end   = ({1'b0, col_r} >= cfg.col_last);
  assign frame_end = row_end && ({1'b0, row_r} >= cfg.row_last);
  assign last_pix  = frame_end || (idx_r == LAST_IDX);
  assign shifted   = PIXEL_W'(head_group[idx_r]) << cfg.shift;

  // retire the group on its last pixel or at the end of the frame
  assign pop = emit && last_pix;

  // pixel index and position counters
  always_comb begin
    idx_nxt = idx_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (emit) begin
      idx_nxt = last_pix ? '0 : idx_r + IDX_W'(1);
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + COORD_W'(1);
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
  end

  // output register contents
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = qstat.not_empty;
    end
    if (emit) begin
      out_data_nxt = '{pixel: shifted, column: col_r, row: row_r,
                       last_in_group: last_pix, end_of_frame: frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/packed_raw_pixel_unpacker_top.sv
// Path: a group taken on in_ goes into a queue slot, then its pixels pass one at a time
//   through the single output register to out_. A two-group queue lets input run ahead.
// Throughput: one pixel per cycle while out_ready holds and a group is queued; fewer
//   pixels come from a group in which the frame ends.
// Reset (synchronous, rst_n low): position returns to column 0 row 0, queue empties,
//   geometry becomes a 1 x 1 frame with a shift of 4.
// Depends on pru_pkg, pru_front, pru_queue and pru_back.
`default_nettype none

module packed_raw_pixel_unpacker_top (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  pru_pkg::pru_in_t        in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output pru_pkg::pru_out_t             out_data,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [pru_pkg::DIM_W-1:0]     cfg_data
);
  import pru_pkg::*;

  pru_qstat_t qstat;
  pru_group_t push_group;
  pru_group_t head_group;
  pru_cfg_t   cfg;
  logic       push;
  logic       pop;

  // unpacking and configuration
  pru_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .push_group (push_group),
    .cfg        (cfg)
  );

  // group queue
  pru_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head_group (head_group),
    .qstat      (qstat)
  );

  // pixel sequencer and output stage
  pru_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .qstat      (qstat),
    .head_group (head_group),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: dv/packed_raw_pixel_unpacker_top_test.sv
// self-checking testbench for packed_raw_pixel_unpacker_top: drives 16-byte groups and
// geometry writes, predicts every unpacked pixel with its position and checks it on out_
// depends on pru_pkg and the rtl of the block only
`timescale 1ns / 100ps
`default_nettype none

module packed_raw_pixel_unpacker_top_test;
  import pru_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pru_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pru_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  packed_raw_pixel_unpacker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // groups waiting for the driver, pixels waiting for the block
  pru_in_t  queued_groups[$];
  pru_out_t pending_pixels[$];

  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  // geometry and position as the block should hold them
  logic [DIM_W-1:0]   geo_width = 15'd1;
  logic [DIM_W-1:0]   geo_height = 15'd1;
  logic [SHIFT_W-1:0] geo_shift = 3'd4;
  logic [COORD_W-1:0] col_pos = '0;
  logic [COORD_W-1:0] row_pos = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  // expected pixels of one group, advancing the frame position
  task automatic unpack_group(input pru_in_t grp);
    logic [RAW_W-1:0] raw [GROUP_PIXELS];
    int unsigned      w;
    int unsigned      h;
    int unsigned      sh;
    logic             row_end;
    logic             frame_end;
    pru_out_t         px;
    raw[0] = {grp.word0[12:10], grp.word0[8:0]};
    raw[1] = {grp.word0[25:20], grp.word0[18:13]};
    raw[2] = {grp.word1[8:0],   grp.word0[28:26]};
    raw[3] = {grp.word1[22:20], grp.word1[18:10]};
    raw[4] = {grp.word2[5:0],   grp.word1[28:23]};
    raw[5] = {grp.word2[18:10], grp.word2[8:6]};
    raw[6] = {grp.word3[2:0],   grp.word2[28:20]};
    raw[7] = {grp.word3[15:10], grp.word3[8:3]};
    raw[8] = {grp.word3[28:20], grp.word3[18:16]};
    // zero reads as one, oversize saturates
    w = (geo_width == 0) ? 1 : (geo_width > MAX_WIDTH) ? MAX_WIDTH : geo_width;
    h = (geo_height == 0) ? 1 : (geo_height > MAX_HEIGHT) ? MAX_HEIGHT : geo_height;
    sh = (geo_shift > MAX_SHIFT) ? MAX_SHIFT : geo_shift;
    for (int k = 0; k < GROUP_PIXELS; k++) begin
      row_end = (int'(col_pos) >= int'(w) - 1);
      frame_end = row_end && (int'(row_pos) >= int'(h) - 1);
      px.pixel = {4'b0000, raw[k]} << sh;
      px.column = col_pos;
      px.row = row_pos;
      px.last_in_group = frame_end || (k == GROUP_PIXELS - 1);
      px.end_of_frame = frame_end;
      pending_pixels.push_back(px);
      if (frame_end) begin
        // rest of the group is dropped
        col_pos = '0;
        row_pos = '0;
        break;
      end
      if (row_end) begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end
  endtask

  // input driver: holds each transaction until taken, gaps at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (queued_groups.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        in_valid <= 1'b1;
        in_data <= queued_groups.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls at random
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // checker and predictor, sampled at the edge
  always @(posedge clk) begin : scoreboard
    pru_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.pixel !== want.pixel || out_data.column !== want.column ||
              out_data.row !== want.row || out_data.last_in_group !== want.last_in_group ||
              out_data.end_of_frame !== want.end_of_frame) begin
            errors++;
            $display("%0t: mismatch expected pix=%h col=%0d row=%0d last=%b eof=%b",
                     $time, want.pixel, want.column, want.row, want.last_in_group,
                     want.end_of_frame);
            $display("%0t:            actual pix=%h col=%0d row=%0d last=%b eof=%b",
                     $time, out_data.pixel, out_data.column, out_data.row,
                     out_data.last_in_group, out_data.end_of_frame);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  geo_width = cfg_data;
          REG_FRAME_HEIGHT: geo_height = cfg_data;
          REG_VALUE_SHIFT:  geo_shift = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) unpack_group(in_data);
    end
  end

  // block until every queued group has been unpacked and checked
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_groups.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_words(input logic [31:0] a, b, c, d);
    pru_in_t grp;
    grp = {a, b, c, d};
    queued_groups.push_back(grp);
  endtask

  function automatic logic [31:0] random_word();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_words(random_word(), random_word(), random_word(),
                                           random_word());
  endtask

  // random geometry, mostly small frames so frames end often
  task automatic random_geometry();
    int unsigned pick;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    pick = $urandom_range(19);
    w = (pick == 0) ? 15'd0 : (pick == 1) ? DIM_W'($urandom_range(16385, 32767)) :
        (pick == 2) ? DIM_W'(MAX_WIDTH) : DIM_W'($urandom_range(1, 24));
    pick = $urandom_range(19);
    h = (pick == 0) ? 15'd0 : (pick == 1) ? DIM_W'($urandom_range(16385, 32767)) :
        DIM_W'($urandom_range(1, 5));
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    write_register(REG_VALUE_SHIFT, {12'($urandom_range(0, 4095)),
                                     3'($urandom_range(0, 7))});
  endtask

  initial begin
    sender_gap_pct = 14;
    sink_stall_pct = 75;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: 1 x 1 frame, one pixel per group
    send_words(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_words(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // zero width and height read as one, no shift
    write_register(REG_FRAME_WIDTH, 15'd0);
    write_register(REG_FRAME_HEIGHT, 15'd0);
    write_register(REG_VALUE_SHIFT, 15'd0);
    send_words(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

    // oversize width and shift saturate, largest height
    write_register(REG_FRAME_WIDTH, 15'h7FFF);
    write_register(REG_FRAME_HEIGHT, DIM_W'(MAX_HEIGHT));
    write_register(REG_VALUE_SHIFT, 15'h7FFF);
    send_words(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_random(5);

    // narrowing mid-row ends the row at once, then frame end inside a group
    write_register(REG_FRAME_WIDTH, 15'd4);
    write_register(REG_FRAME_HEIGHT, 15'd2);
    write_register(REG_VALUE_SHIFT, 15'd5);
    send_random(3);

    // lowering height below the current row ends the frame at the next row end
    write_register(REG_FRAME_WIDTH, 15'd2);
    write_register(REG_FRAME_HEIGHT, DIM_W'(MAX_HEIGHT));
    send_random(2);
    write_register(REG_FRAME_HEIGHT, 15'd3);
    write_register(REG_SPARE, 15'h7FFF);
    send_random(1);

    // frame of exactly one group
    write_register(REG_FRAME_WIDTH, 15'd3);
    write_register(REG_FRAME_HEIGHT, 15'd3);
    write_register(REG_VALUE_SHIFT, 15'd1);
    send_random(2);

    // random part over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      sender_gap_pct = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
      sink_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 14 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        random_geometry();
        send_random(28);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
